// ----- sv/dmce_pkg.sv -----
// Shared types, codes and helper functions for the dual motor command encoder.
`default_nettype none

package dmce_pkg;

  // Request codes carried in the request type field.
  typedef enum logic [3:0] {
    REQ_FWD    = 4'd0,
    REQ_BACK   = 4'd1,
    REQ_LEFT   = 4'd2,
    REQ_RIGHT  = 4'd3,
    REQ_CW     = 4'd4,
    REQ_CCW    = 4'd5,
    REQ_STOP   = 4'd6,
    REQ_INDIV  = 4'd7,
    REQ_INIT   = 4'd8,
    REQ_WRDONE = 4'd9
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_BUS_ERR  = 2'd2,
    ST_BUSY     = 2'd3
  } status_e;

  localparam int unsigned DutyW  = 12;
  localparam int unsigned LevelW = 13;
  localparam logic [15:0] RefreshReset = 16'd1000;

  // Six driver channel levels. A direction pin is either full on or off, so one bit holds it.
  typedef struct packed {
    logic              r_in1;
    logic              r_in2;
    logic [DutyW-1:0]  r_duty;
    logic              l_in1;
    logic              l_in2;
    logic [DutyW-1:0]  l_duty;
  } levels_t;

  // Wheel speed and direction state.
  typedef struct packed {
    logic       r_fwd;
    logic       l_fwd;
    logic [7:0] r_speed;
    logic [7:0] l_speed;
  } motion_t;

  // Duty for an 8-bit speed: s*16 + s/17. The division uses the reciprocal 241/4096,
  // which is exact for every 8-bit speed.
  function automatic logic [DutyW-1:0] duty_of(input logic [7:0] s);
    logic [15:0] prod;
    logic [3:0]  quot;
    prod = 16'(s) * 16'd241;
    quot = prod[15:12];
    return {s, 4'b0000} + 12'(quot);
  endfunction

  // Full-on pin level for a direction bit.
  function automatic logic [LevelW-1:0] pin_level(input logic on);
    return {on, 12'b0};
  endfunction

endpackage

`default_nettype wire

// ----- sv/dual_motor_command_encoder.sv -----
// Top level of the dual motor command encoder: command decode, write cache and result register.
`default_nettype none

// The block takes one command beat per cycle while the output side is not stalled and returns
// one result beat for each, held first in an input register and then in the result register.
// Once the result slot is free or being emptied, the decode, the cache compare and the refresh
// check run in one pass and the result, together with the updated cache, pending-write and
// wheel state, is loaded into the result register. Since the state is updated in the same cycle
// the result is formed, each command sees exactly what the one before it left. The output
// register lets a new command enter while a finished result still waits to be taken. The refresh
// interval register must only be written while no command is in flight.
module dual_motor_command_encoder import dmce_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  // Command channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         req_type_i,
  input  wire logic [7:0]         speed_i,
  input  wire logic [7:0]         left_speed_in_i,
  input  wire logic [7:0]         right_speed_in_i,
  input  wire logic               left_forward_in_i,
  input  wire logic               right_forward_in_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               bus_ok_i,
  // Result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    write_issued_o,
  output logic [LevelW-1:0]       right_in1_o,
  output logic [LevelW-1:0]       right_in2_o,
  output logic [DutyW-1:0]        right_duty_o,
  output logic [LevelW-1:0]       left_in1_o,
  output logic [LevelW-1:0]       left_in2_o,
  output logic [DutyW-1:0]        left_duty_o,
  output logic [1:0]              status_o,
  output logic [7:0]              left_speed_now_o,
  output logic [7:0]              right_speed_now_o,
  output logic                    left_forward_now_o,
  output logic                    right_forward_now_o
);

  // Configuration register.
  logic [15:0] refresh_q;

  // Input register.
  logic        s1_valid_q;
  logic [3:0]  req_q;
  logic [7:0]  speed_q;
  logic [7:0]  ls_in_q;
  logic [7:0]  rs_in_q;
  logic        lf_in_q;
  logic        rf_in_q;
  logic [31:0] now_q;
  logic        ok_q;

  // Persistent state.
  levels_t     cache_lv_q,  cache_lv_d;
  logic        cache_valid_q, cache_valid_d;
  logic [31:0] cache_time_q, cache_time_d;
  levels_t     pend_lv_q,   pend_lv_d;
  logic [31:0] pend_time_q, pend_time_d;
  motion_t     pend_mot_q,  pend_mot_d;
  logic        wr_pend_q,   wr_pend_d;
  logic        pend_init_q, pend_init_d;
  logic        ready_q,     ready_d;
  motion_t     commit_q,    commit_d;

  // Result register.
  logic        out_valid_q;
  logic        issued_q,    issued_d;
  levels_t     res_lv_q,    res_lv_d;
  status_e     status_q,    status_d;

  logic        advance;
  logic        in_accept;

  // A command moves into the result register when the result slot is free or being emptied.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // Refresh interval register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= RefreshReset;
    end else if (cfg_we_i) begin
      refresh_q <= cfg_wdata_i;
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q   <= req_type_i;
      speed_q <= speed_i;
      ls_in_q <= left_speed_in_i;
      rs_in_q <= right_speed_in_i;
      lf_in_q <= left_forward_in_i;
      rf_in_q <= right_forward_in_i;
      now_q   <= now_ms_i;
      ok_q    <= bus_ok_i;
    end
  end

  // Command decode, cache check and state update for the beat in the input register.
  always_comb begin
    req_e        req;
    logic        is_cmd;
    logic        is_init;
    logic        drive;
    logic        r_fwd;
    logic        l_fwd;
    logic [7:0]  r_spd;
    logic [7:0]  l_spd;
    logic [7:0]  half;
    levels_t     lv;
    motion_t     mot;
    logic [31:0] age;
    logic        hit;

    req     = req_e'(req_q);
    is_cmd  = (req_q <= REQ_INIT);
    is_init = (req == REQ_INIT);
    half    = speed_q >> 1;
    drive   = 1'b1;
    r_fwd   = 1'b1;
    l_fwd   = 1'b1;
    r_spd   = speed_q;
    l_spd   = speed_q;

    // Wheel targets per command.
    case (req)
      REQ_FWD: begin
      end
      REQ_BACK: begin
        r_fwd = 1'b0;
        l_fwd = 1'b0;
      end
      REQ_LEFT: begin
        l_spd = half;
      end
      REQ_RIGHT: begin
        r_spd = half;
      end
      REQ_CW: begin
        r_fwd = 1'b0;
      end
      REQ_CCW: begin
        l_fwd = 1'b0;
      end
      REQ_INDIV: begin
        r_fwd = rf_in_q;
        l_fwd = lf_in_q;
        r_spd = rs_in_q;
        l_spd = ls_in_q;
      end
      default: begin
        drive = 1'b0;
      end
    endcase

    // Channel levels and motion word; stop and init turn everything off.
    lv  = '0;
    mot = '0;
    if (drive) begin
      lv.r_in1   = r_fwd;
      lv.r_in2   = !r_fwd;
      lv.r_duty  = duty_of(r_spd);
      lv.l_in1   = l_fwd;
      lv.l_in2   = !l_fwd;
      lv.l_duty  = duty_of(l_spd);
      mot.r_fwd   = r_fwd;
      mot.l_fwd   = l_fwd;
      mot.r_speed = r_spd;
      mot.l_speed = l_spd;
    end

    // Same levels still held by the driver and not yet due for a refresh.
    age = now_q - cache_time_q;
    hit = cache_valid_q && (lv == cache_lv_q) && (age < {16'b0, refresh_q});

    cache_lv_d    = cache_lv_q;
    cache_valid_d = cache_valid_q;
    cache_time_d  = cache_time_q;
    pend_lv_d     = pend_lv_q;
    pend_time_d   = pend_time_q;
    pend_mot_d    = pend_mot_q;
    wr_pend_d     = wr_pend_q;
    pend_init_d   = pend_init_q;
    ready_d       = ready_q;
    commit_d      = commit_q;
    issued_d      = 1'b0;
    res_lv_d      = '0;
    status_d      = ST_OK;

    if (is_cmd) begin
      if (!ready_q && req != REQ_STOP && !is_init) begin
        status_d = ST_NOT_INIT;
      end else if (is_init && ready_q) begin
        status_d = ST_OK;
      end else if (wr_pend_q) begin
        status_d = ST_BUSY;
      end else begin
        res_lv_d = lv;
        if (hit) begin
          commit_d = mot;
          if (is_init) begin
            ready_d = 1'b1;
          end
        end else begin
          issued_d    = 1'b1;
          pend_lv_d   = lv;
          pend_time_d = now_q;
          pend_mot_d  = mot;
          wr_pend_d   = 1'b1;
          pend_init_d = is_init;
        end
      end
    end else if (req == REQ_WRDONE && wr_pend_q) begin
      // Completion of the outstanding driver write.
      res_lv_d  = pend_lv_q;
      wr_pend_d = 1'b0;
      if (ok_q) begin
        cache_lv_d    = pend_lv_q;
        cache_time_d  = pend_time_q;
        cache_valid_d = 1'b1;
        commit_d      = pend_mot_q;
      end else begin
        cache_valid_d = 1'b0;
        status_d      = ST_BUS_ERR;
      end
      if (pend_init_q) begin
        ready_d  = 1'b1;
        status_d = ST_OK;
      end
      pend_init_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_lv_q    <= '0;
      cache_valid_q <= 1'b0;
      cache_time_q  <= '0;
      wr_pend_q     <= 1'b0;
      pend_init_q   <= 1'b0;
      ready_q       <= 1'b0;
      commit_q      <= '0;
    end else if (advance) begin
      cache_lv_q    <= cache_lv_d;
      cache_valid_q <= cache_valid_d;
      cache_time_q  <= cache_time_d;
      wr_pend_q     <= wr_pend_d;
      pend_init_q   <= pend_init_d;
      ready_q       <= ready_d;
      commit_q      <= commit_d;
    end
  end

  // Pending write contents; only read while a write is pending.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pend_lv_q   <= pend_lv_d;
      pend_time_q <= pend_time_d;
      pend_mot_q  <= pend_mot_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      issued_q <= issued_d;
      res_lv_q <= res_lv_d;
      status_q <= status_d;
    end
  end

  // Result beat fields; the wheel state shown is the committed state after the command.
  assign out_valid_o         = out_valid_q;
  assign write_issued_o      = issued_q;
  assign right_in1_o         = pin_level(res_lv_q.r_in1);
  assign right_in2_o         = pin_level(res_lv_q.r_in2);
  assign right_duty_o        = res_lv_q.r_duty;
  assign left_in1_o          = pin_level(res_lv_q.l_in1);
  assign left_in2_o          = pin_level(res_lv_q.l_in2);
  assign left_duty_o         = res_lv_q.l_duty;
  assign status_o            = status_q;
  assign left_speed_now_o    = commit_q.l_speed;
  assign right_speed_now_o   = commit_q.r_speed;
  assign left_forward_now_o  = commit_q.l_fwd;
  assign right_forward_now_o = commit_q.r_fwd;

endmodule

`default_nettype wire

// ----- sv/dmce_checker.sv -----
// Port-level checker for the dual motor command encoder, bound to the top level.
`default_nettype none

module dmce_checker import dmce_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               write_issued_o,
  input wire logic [LevelW-1:0]  right_in1_o,
  input wire logic [LevelW-1:0]  right_in2_o,
  input wire logic [DutyW-1:0]   right_duty_o,
  input wire logic [LevelW-1:0]  left_in1_o,
  input wire logic [LevelW-1:0]  left_in2_o,
  input wire logic [DutyW-1:0]   left_duty_o,
  input wire logic [1:0]         status_o
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_issued_o)
      && $stable(status_o) && $stable(right_duty_o) && $stable(left_duty_o))
    else $error("result beat changed while stalled");

  // An issued write always reports success.
  a_issue_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_issued_o |-> status_o == ST_OK)
    else $error("write issued with a failing status");

  // Refused commands carry no channel levels.
  a_refused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BUSY || status_o == ST_NOT_INIT) |->
      !write_issued_o && right_in1_o == '0 && right_in2_o == '0 && right_duty_o == '0
      && left_in1_o == '0 && left_in2_o == '0 && left_duty_o == '0)
    else $error("refused command shows channel levels");

  // Both direction pins of one wheel are never on together.
  a_pins_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(right_in1_o[12] && right_in2_o[12]) && !(left_in1_o[12] && left_in2_o[12]))
    else $error("both direction pins on");

  // The right wheel, when both its pins are off, has zero duty.
  a_off_no_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !right_in1_o[12] && !right_in2_o[12] |-> right_duty_o == '0)
    else $error("duty without direction");

endmodule

bind dual_motor_command_encoder dmce_checker u_dmce_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_dual_motor_command_encoder.sv -----
// Self-checking testbench for the dual motor command encoder, with its own command predictor.
module tb_dual_motor_command_encoder;
  import dmce_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [12:0] FullOn = 13'd4096;
  // Request codes the block does not define; it must ignore them.
  localparam logic [3:0] ReqUnusedLo = 4'd10;
  localparam logic [3:0] ReqUnusedHi = 4'd15;

  // One command beat as the sender drives it.
  typedef struct packed {
    logic [3:0]  req;
    logic [7:0]  speed;
    logic [7:0]  l_spd;
    logic [7:0]  r_spd;
    logic        l_fwd;
    logic        r_fwd;
    logic [31:0] now;
    logic        bus_ok;
  } cmd_t;

  // The six driver channel levels, right wheel first.
  typedef struct packed {
    logic [12:0] r_in1;
    logic [12:0] r_in2;
    logic [11:0] r_duty;
    logic [12:0] l_in1;
    logic [12:0] l_in2;
    logic [11:0] l_duty;
  } levels6_t;

  // Committed wheel speeds and directions.
  typedef struct packed {
    logic [7:0] l_spd;
    logic [7:0] r_spd;
    logic       l_fwd;
    logic       r_fwd;
  } wheels_t;

  // One result beat.
  typedef struct packed {
    logic     issued;
    levels6_t lv;
    status_e  st;
    wheels_t  wh;
  } result_t;

  // A row of the directed table; typed rows carry their expected result.
  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t want;
  } step_row_t;

  localparam levels6_t LvOff = '0;
  localparam levels6_t LvFullFwd = {13'd4096, 13'd0, 12'd4095, 13'd4096, 13'd0, 12'd4095};
  localparam wheels_t WhIdle = '0;
  localparam wheels_t WhFullFwd = {8'd255, 8'd255, 1'b1, 1'b1};

  // Clock, reset and block ports.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  req_type_i = '0;
  logic [7:0]  speed_i = '0;
  logic [7:0]  left_speed_in_i = '0;
  logic [7:0]  right_speed_in_i = '0;
  logic        left_forward_in_i = 1'b0;
  logic        right_forward_in_i = 1'b0;
  logic [31:0] now_ms_i = '0;
  logic        bus_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        write_issued_o;
  logic [12:0] right_in1_o, right_in2_o, left_in1_o, left_in2_o;
  logic [11:0] right_duty_o, left_duty_o;
  logic [1:0]  status_o;
  logic [7:0]  left_speed_now_o, right_speed_now_o;
  logic        left_forward_now_o, right_forward_now_o;

  // Predictor state.
  logic [15:0] refresh_ms = 16'd1000;
  levels6_t    cache_lv = '0;
  logic        cache_ok = 1'b0;
  logic [31:0] cache_t = '0;
  levels6_t    pend_lv = '0;
  logic [31:0] pend_t = '0;
  wheels_t     pend_wh = '0;
  logic        wr_pending = 1'b0;
  logic        pend_init = 1'b0;
  logic        drv_ready = 1'b0;
  wheels_t     committed = '0;

  // Scoreboard and run bookkeeping.
  result_t     awaited_outputs[$];
  step_row_t   directed_rows[$];
  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned beats_sent = 0;
  int unsigned items_counted = 0;
  int unsigned results_seen = 0;
  int unsigned writes_issued = 0;
  int unsigned writes_skipped = 0;
  int unsigned status_tally[4] = '{0, 0, 0, 0};
  int          sink_hold = 0;
  bit          sender_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  logic [31:0] tb_now = '0;

  dual_motor_command_encoder u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .speed_i            (speed_i),
    .left_speed_in_i    (left_speed_in_i),
    .right_speed_in_i   (right_speed_in_i),
    .left_forward_in_i  (left_forward_in_i),
    .right_forward_in_i (right_forward_in_i),
    .now_ms_i           (now_ms_i),
    .bus_ok_i           (bus_ok_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .write_issued_o     (write_issued_o),
    .right_in1_o        (right_in1_o),
    .right_in2_o        (right_in2_o),
    .right_duty_o       (right_duty_o),
    .left_in1_o         (left_in1_o),
    .left_in2_o         (left_in2_o),
    .left_duty_o        (left_duty_o),
    .status_o           (status_o),
    .left_speed_now_o   (left_speed_now_o),
    .right_speed_now_o  (right_speed_now_o),
    .left_forward_now_o (left_forward_now_o),
    .right_forward_now_o(right_forward_now_o)
  );

  // Free-running clock and cycle counter.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Channel levels for both wheels; duty is floor(s * 4095 / 255).
  function automatic levels6_t drive_levels(logic r_fwd, logic [7:0] r_s,
                                            logic l_fwd, logic [7:0] l_s);
    levels6_t lv;
    lv.r_in1  = r_fwd ? FullOn : 13'd0;
    lv.r_in2  = r_fwd ? 13'd0 : FullOn;
    lv.r_duty = 12'((r_s * 4095) / 255);
    lv.l_in1  = l_fwd ? FullOn : 13'd0;
    lv.l_in2  = l_fwd ? 13'd0 : FullOn;
    lv.l_duty = 12'((l_s * 4095) / 255);
    return lv;
  endfunction

  // Works out the result of one command and advances the predictor state.
  function automatic result_t encode_command(cmd_t c);
    result_t    r;
    levels6_t   lv;
    wheels_t    wh;
    logic [7:0] half;
    bit         is_init;
    r = '0;
    lv = '0;
    wh = '0;
    half = c.speed >> 1;
    is_init = (c.req == REQ_INIT);
    if (c.req <= REQ_INIT) begin
      if (!drv_ready && c.req != REQ_STOP && !is_init) begin
        r.st = ST_NOT_INIT;
      end else if (is_init && drv_ready) begin
        r.st = ST_OK;
      end else if (wr_pending) begin
        r.st = ST_BUSY;
      end else begin
        case (c.req)
          REQ_FWD: begin
            lv = drive_levels(1'b1, c.speed, 1'b1, c.speed);
            wh = {c.speed, c.speed, 1'b1, 1'b1};
          end
          REQ_BACK: begin
            lv = drive_levels(1'b0, c.speed, 1'b0, c.speed);
            wh = {c.speed, c.speed, 1'b0, 1'b0};
          end
          REQ_LEFT: begin
            lv = drive_levels(1'b1, c.speed, 1'b1, half);
            wh = {half, c.speed, 1'b1, 1'b1};
          end
          REQ_RIGHT: begin
            lv = drive_levels(1'b1, half, 1'b1, c.speed);
            wh = {c.speed, half, 1'b1, 1'b1};
          end
          REQ_CW: begin
            lv = drive_levels(1'b0, c.speed, 1'b1, c.speed);
            wh = {c.speed, c.speed, 1'b1, 1'b0};
          end
          REQ_CCW: begin
            lv = drive_levels(1'b1, c.speed, 1'b0, c.speed);
            wh = {c.speed, c.speed, 1'b0, 1'b1};
          end
          REQ_INDIV: begin
            lv = drive_levels(c.r_fwd, c.r_spd, c.l_fwd, c.l_spd);
            wh = {c.l_spd, c.r_spd, c.l_fwd, c.r_fwd};
          end
          default: begin
            lv = '0;
            wh = '0;
          end
        endcase
        r.lv = lv;
        // An unchanged write inside the refresh interval is skipped and commits at once.
        if (cache_ok && lv == cache_lv && (c.now - cache_t) < {16'd0, refresh_ms}) begin
          committed = wh;
          if (is_init) drv_ready = 1'b1;
          writes_skipped++;
        end else begin
          r.issued = 1'b1;
          pend_lv = lv;
          pend_t = c.now;
          pend_wh = wh;
          wr_pending = 1'b1;
          pend_init = is_init;
        end
      end
    end else if (c.req == REQ_WRDONE && wr_pending) begin
      // Completion: commit on success, drop the cache on failure.
      r.lv = pend_lv;
      wr_pending = 1'b0;
      if (c.bus_ok) begin
        cache_lv = pend_lv;
        cache_t = pend_t;
        cache_ok = 1'b1;
        committed = pend_wh;
      end else begin
        cache_ok = 1'b0;
        r.st = ST_BUS_ERR;
      end
      if (pend_init) begin
        drv_ready = 1'b1;
        r.st = ST_OK;
      end
      pend_init = 1'b0;
    end
    r.wh = committed;
    return r;
  endfunction

  function automatic cmd_t mk_cmd(logic [3:0] req, logic [7:0] sp, logic [31:0] now,
                                  bit ok = 1'b1, logic [7:0] ls = '0, logic [7:0] rs = '0,
                                  bit lf = 1'b0, bit rf = 1'b0);
    cmd_t c;
    c.req = req;
    c.speed = sp;
    c.l_spd = ls;
    c.r_spd = rs;
    c.l_fwd = lf;
    c.r_fwd = rf;
    c.now = now;
    c.bus_ok = ok;
    return c;
  endfunction

  function automatic result_t mk_result(bit issued, levels6_t lv, status_e st, wheels_t wh);
    result_t r;
    r.issued = issued;
    r.lv = lv;
    r.st = st;
    r.wh = wh;
    return r;
  endfunction

  function automatic void add_row(cmd_t c, bit typed = 1'b0, result_t want = '0);
    step_row_t row;
    row.c = c;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // Speeds lean toward the corners of the range.
  function automatic logic [7:0] pick_speed();
    if ($urandom_range(0, 99) < 60) return 8'($urandom);
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Time steps: often none, often inside the interval, some right at its edge, some far off.
  function automatic logic [31:0] next_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      tb_now = tb_now;
    end else if (r < 65) begin
      tb_now = tb_now + $urandom_range(0, refresh_ms);
    end else if (r < 85) begin
      tb_now = cache_t + refresh_ms - 1 + $urandom_range(0, 2);
    end else if (r < 95) begin
      tb_now = tb_now + $urandom_range(0, 3 * refresh_ms);
    end else begin
      tb_now = $urandom;
    end
    return tb_now;
  endfunction

  function automatic cmd_t fresh_motion_cmd();
    return mk_cmd(4'($urandom_range(0, 8)), pick_speed(), tb_now, 1'($urandom),
                  pick_speed(), pick_speed(), 1'($urandom), 1'($urandom));
  endfunction

  // Compares a result beat with the oldest expectation, field by field.
  task automatic check_result(result_t got);
    result_t want;
    string   diffs;
    results_seen++;
    if (awaited_outputs.size() == 0) begin
      err_count++;
      if (err_count <= 10) $display("Result beat %0d arrived with nothing expected", results_seen);
      return;
    end
    want = awaited_outputs.pop_front();
    diffs = "";
    if (got.issued !== want.issued)
      diffs = {diffs, $sformatf(" write_issued %0d/%0d", want.issued, got.issued)};
    if (got.lv.r_in1 !== want.lv.r_in1)
      diffs = {diffs, $sformatf(" right_in1 %0d/%0d", want.lv.r_in1, got.lv.r_in1)};
    if (got.lv.r_in2 !== want.lv.r_in2)
      diffs = {diffs, $sformatf(" right_in2 %0d/%0d", want.lv.r_in2, got.lv.r_in2)};
    if (got.lv.r_duty !== want.lv.r_duty)
      diffs = {diffs, $sformatf(" right_duty %0d/%0d", want.lv.r_duty, got.lv.r_duty)};
    if (got.lv.l_in1 !== want.lv.l_in1)
      diffs = {diffs, $sformatf(" left_in1 %0d/%0d", want.lv.l_in1, got.lv.l_in1)};
    if (got.lv.l_in2 !== want.lv.l_in2)
      diffs = {diffs, $sformatf(" left_in2 %0d/%0d", want.lv.l_in2, got.lv.l_in2)};
    if (got.lv.l_duty !== want.lv.l_duty)
      diffs = {diffs, $sformatf(" left_duty %0d/%0d", want.lv.l_duty, got.lv.l_duty)};
    if (got.st !== want.st)
      diffs = {diffs, $sformatf(" status %0d/%0d", want.st, got.st)};
    if (got.wh.l_spd !== want.wh.l_spd)
      diffs = {diffs, $sformatf(" left_speed_now %0d/%0d", want.wh.l_spd, got.wh.l_spd)};
    if (got.wh.r_spd !== want.wh.r_spd)
      diffs = {diffs, $sformatf(" right_speed_now %0d/%0d", want.wh.r_spd, got.wh.r_spd)};
    if (got.wh.l_fwd !== want.wh.l_fwd)
      diffs = {diffs, $sformatf(" left_forward_now %0d/%0d", want.wh.l_fwd, got.wh.l_fwd)};
    if (got.wh.r_fwd !== want.wh.r_fwd)
      diffs = {diffs, $sformatf(" right_forward_now %0d/%0d", want.wh.r_fwd, got.wh.r_fwd)};
    if (diffs != "") begin
      err_count++;
      if (err_count <= 10)
        $display("Result beat %0d mismatch (expected/actual):%s", results_seen, diffs);
    end
  endtask

  // Sends one command beat; valid stays up after acceptance unless the next beat idles first.
  task automatic send_cmd(cmd_t c, bit typed = 1'b0, result_t want = '0);
    int      gap;
    bit      ignored;
    result_t pred;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= c.req;
    speed_i <= c.speed;
    left_speed_in_i <= c.l_spd;
    right_speed_in_i <= c.r_spd;
    left_forward_in_i <= c.l_fwd;
    right_forward_in_i <= c.r_fwd;
    now_ms_i <= c.now;
    bus_ok_i <= c.bus_ok;
    do @(posedge clk_i); while (!in_ready_o);
    ignored = (c.req > REQ_WRDONE) || (c.req == REQ_WRDONE && !wr_pending);
    pred = encode_command(c);
    awaited_outputs.push_back(typed ? want : pred);
    beats_sent++;
    if (!ignored) items_counted++;
    if (pred.issued) writes_issued++;
    status_tally[pred.st]++;
  endtask

  // Holds the sender off until every expected result has been taken.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_outputs.size() != 0);
  endtask

  task automatic set_refresh(logic [15:0] ms);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    refresh_ms = ms;
  endtask

  // Result side: check every accepted beat and stall at random.
  always @(posedge clk_i) begin
    result_t got;
    int      stall;
    if (out_valid_o && out_ready_i) begin
      got.issued = write_issued_o;
      got.lv = {right_in1_o, right_in2_o, right_duty_o, left_in1_o, left_in2_o, left_duty_o};
      got.st = status_e'(status_o);
      got.wh = {left_speed_now_o, right_speed_now_o, left_forward_now_o, right_forward_now_o};
      check_result(got);
    end
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (out_ready_i) begin
      stall = pick_gap(sink_quiet);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        sink_hold = stall - 1;
      end else begin
        sink_hold = $urandom_range(0, 7);
      end
    end else begin
      out_ready_i <= 1'b1;
      sink_hold = $urandom_range(0, 7);
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             awaited_outputs.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    logic [15:0] phase_ms[6];
    cmd_t        repeat_cmd;
    int unsigned target;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the refresh interval at its reset value of 1000 ms.
    add_row(mk_cmd(REQ_FWD, 8'd100, 32'd0), 1'b1, mk_result(1'b0, LvOff, ST_NOT_INIT, WhIdle));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd1), 1'b1, mk_result(1'b0, LvOff, ST_OK, WhIdle));
    add_row(mk_cmd(ReqUnusedLo, 8'd0, 32'd2), 1'b1, mk_result(1'b0, LvOff, ST_OK, WhIdle));
    add_row(mk_cmd(ReqUnusedHi, 8'd255, '1), 1'b1, mk_result(1'b0, LvOff, ST_OK, WhIdle));
    add_row(mk_cmd(REQ_STOP, 8'd0, 32'd10), 1'b1, mk_result(1'b1, LvOff, ST_OK, WhIdle));
    add_row(mk_cmd(REQ_BACK, 8'd255, 32'd11), 1'b1,
            mk_result(1'b0, LvOff, ST_NOT_INIT, WhIdle));
    add_row(mk_cmd(REQ_INIT, 8'd0, 32'd12), 1'b1, mk_result(1'b0, LvOff, ST_BUSY, WhIdle));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd13, 1'b0), 1'b1,
            mk_result(1'b0, LvOff, ST_BUS_ERR, WhIdle));
    add_row(mk_cmd(REQ_INIT, 8'd0, 32'd20), 1'b1, mk_result(1'b1, LvOff, ST_OK, WhIdle));
    // A failed init write still marks the driver ready.
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd21, 1'b0), 1'b1,
            mk_result(1'b0, LvOff, ST_OK, WhIdle));
    add_row(mk_cmd(REQ_INIT, 8'd0, 32'd22), 1'b1, mk_result(1'b0, LvOff, ST_OK, WhIdle));
    add_row(mk_cmd(REQ_FWD, 8'd255, 32'd100), 1'b1,
            mk_result(1'b1, LvFullFwd, ST_OK, WhIdle));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd101), 1'b1,
            mk_result(1'b0, LvFullFwd, ST_OK, WhFullFwd));
    // Same levels one millisecond inside the interval, then exactly at its end.
    add_row(mk_cmd(REQ_FWD, 8'd255, 32'd1099), 1'b1,
            mk_result(1'b0, LvFullFwd, ST_OK, WhFullFwd));
    add_row(mk_cmd(REQ_FWD, 8'd255, 32'd1100), 1'b1,
            mk_result(1'b1, LvFullFwd, ST_OK, WhFullFwd));
    add_row(mk_cmd(REQ_CCW, 8'd77, 32'd1101), 1'b1,
            mk_result(1'b0, LvOff, ST_BUSY, WhFullFwd));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd1102));
    add_row(mk_cmd(REQ_BACK, 8'd0, 32'd1200));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd1201));
    add_row(mk_cmd(REQ_LEFT, 8'd201, 32'd1300));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd1301, 1'b0));
    add_row(mk_cmd(REQ_RIGHT, 8'd1, 32'd1400));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd1401));
    add_row(mk_cmd(REQ_CW, 8'd128, 32'd1500));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd1501));
    add_row(mk_cmd(REQ_CCW, 8'd77, 32'd1600));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'd1601));
    add_row(mk_cmd(REQ_INDIV, 8'd0, 32'hFFFF_FF00, 1'b1, 8'd255, 8'd0, 1'b0, 1'b1));
    add_row(mk_cmd(REQ_WRDONE, 8'd0, 32'hFFFF_FF01));
    // Across the 32-bit time wrap the same command is still inside the interval.
    add_row(mk_cmd(REQ_INDIV, 8'd0, 32'h0000_0010, 1'b1, 8'd255, 8'd0, 1'b0, 1'b1));
    foreach (directed_rows[i]) send_cmd(directed_rows[i].c, directed_rows[i].typed,
                                        directed_rows[i].want);

    // Random phases, each behind a drain and a new refresh interval.
    phase_ms = '{16'd1, 16'd65535, 16'd1000, 16'($urandom_range(2, 64)),
                 16'($urandom_range(1, 65535)), 16'd65535};
    tb_now = 32'h0000_0010;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      set_refresh(phase_ms[p]);
      sender_quiet = (p == 2) || (p == 4);
      sink_quiet = (p == 2) || (p == 5);
      repeat_cmd = fresh_motion_cmd();
      target = items_counted + 165;
      while (items_counted < target) begin
        if ($urandom_range(0, 99) < 80) begin
          // Command followed by its write completion; repeats exercise the write cache.
          if ($urandom_range(0, 99) < 55) repeat_cmd = fresh_motion_cmd();
          repeat_cmd.now = next_now();
          send_cmd(repeat_cmd);
          if ($urandom_range(0, 99) < 90)
            send_cmd(mk_cmd(REQ_WRDONE, 8'($urandom), next_now(),
                            $urandom_range(0, 99) < 85, 8'($urandom), 8'($urandom),
                            1'($urandom), 1'($urandom)));
        end else begin
          send_cmd(mk_cmd(4'($urandom_range(0, ReqUnusedHi)), 8'($urandom),
                          ($urandom_range(0, 1) != 0) ? $urandom : next_now(),
                          1'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom), 1'($urandom)));
        end
      end
    end

    // Drain, then watch a short tail for stray result beats.
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d command beats (%0d not ignored) over 7 refresh settings; %0d writes",
             beats_sent, items_counted, writes_issued);
    $display("Skipped writes %0d; status ok %0d, not init %0d, bus error %0d, busy %0d",
             writes_skipped, status_tally[0], status_tally[1], status_tally[2],
             status_tally[3]);
    if (err_count == 0 && awaited_outputs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", err_count, awaited_outputs.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
